[rtl/core/lnr_pkg.sv]
package lnr_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int INDEX_BITS_DEF = 24;

  localparam int SAMPLE_W  = 16;
  localparam int STEP_W    = 17;
  localparam int LEN_W     = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam int PER_ITEM_CAP = 16;
  localparam int CAP_W        = $clog2(PER_ITEM_CAP + 1);

  localparam logic [STEP_W-1:0] STEP_MIN   = 17'd4096;
  localparam logic [STEP_W-1:0] STEP_MAX   = 17'd65536;
  localparam logic [STEP_W-1:0] STEP_RESET = 17'd65536;

  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = -16'sd32768;
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sd32767;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Q16     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ORIGIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE  = 3'd4;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic MODE_NEAREST = 1'b0;
  localparam logic MODE_LINEAR  = 1'b1;

  typedef struct packed {
    logic start;   // latch input beat, open item
    logic step;    // latch product, advance position and counts
    logic load;    // move finished value into output register
    logic finish;  // commit or clear stream state
  } lnr_cmd_t;

  typedef struct packed {
    logic have_prev;  // an interval is open
    logic more;       // another output falls in the current interval
    logic out_free;   // output register can take a value this cycle
  } lnr_sts_t;

endpackage

[rtl/core/lnr_ctrl.sv]
module lnr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lnr_pkg::lnr_sts_t sts,
  output lnr_pkg::lnr_cmd_t cmd
);
  import lnr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_CALC   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = sts.have_prev ? ST_CHECK : ST_FINISH;
        end
      end
      ST_CHECK: begin
        if (sts.more) begin
          cmd.step   = 1'b1;
          state_next = ST_CALC;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_CALC: begin
        // hand off current value and start the next one in the same cycle
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.more) begin
            cmd.step = 1'b1;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/lnr_datapath.sv]
module lnr_datapath #(
  parameter int FRAC_BITS  = lnr_pkg::FRAC_BITS_DEF,
  parameter int INDEX_BITS = lnr_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lnr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lnr_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_op,
  input  logic signed [lnr_pkg::SAMPLE_W-1:0] in_sample,
  input  lnr_pkg::lnr_cmd_t                   cmd,
  output lnr_pkg::lnr_sts_t                   sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lnr_pkg::SAMPLE_W-1:0] out_data,
  output logic                                out_last
);
  import lnr_pkg::*;

  localparam int POS_W  = INDEX_BITS + FRAC_BITS;
  localparam int SHL    = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
  localparam int SHR    = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RMAG_W = SUM_W - FRAC_BITS;

  // configuration
  logic [STEP_W-1:0] step_q16;
  logic [LEN_W-1:0]  out_length;
  logic              loop_enabled;
  logic [LEN_W-1:0]  loop_origin;
  logic              interp_mode;

  // stream state
  logic [POS_W-1:0]             position_acc;
  logic signed [SAMPLE_W-1:0]   previous_sample;
  logic signed [SAMPLE_W-1:0]   loop_sample;
  logic [INDEX_BITS-1:0]        input_index;
  logic [LEN_W-1:0]             output_count;
  logic                         have_previous;

  // item in flight
  logic                         op_r;
  logic signed [SAMPLE_W-1:0]   sample_r;
  logic [INDEX_BITS-1:0]        seg;
  logic [CAP_W-1:0]             item_cnt;
  logic signed [PROD_W-1:0]     prod;
  logic                         near_hi;
  logic                         last_cnt;

  logic [STEP_W-1:0]            step_clamp;
  logic [POS_W-1:0]             step_frac;
  logic signed [SAMPLE_W-1:0]   next_sample;
  logic signed [DIFF_W-1:0]     diff;
  logic signed [FRAC_BITS:0]    frac_s;
  logic                         more;
  logic [LEN_W-1:0]             count_inc;
  logic signed [SUM_W-1:0]      vsum;
  logic [SUM_W-1:0]             mag;
  logic [SUM_W-1:0]             rnd;
  logic [RMAG_W-1:0]            r_mag;
  logic signed [SAMPLE_W-1:0]   lin_val;
  logic signed [SAMPLE_W-1:0]   near_val;
  logic signed [SAMPLE_W-1:0]   out_val;

  always_comb begin
    priority if (step_q16 < STEP_MIN) begin
      step_clamp = STEP_MIN;
    end else if (step_q16 > STEP_MAX) begin
      step_clamp = STEP_MAX;
    end else begin
      step_clamp = step_q16;
    end
  end

  assign step_frac = (POS_W'(step_clamp) << SHL) >> SHR;

  // flush: next sample is the loop sample or silence
  assign next_sample = (op_r == OP_END) ? (loop_enabled ? loop_sample : '0) : sample_r;
  assign diff        = DIFF_W'(next_sample) - DIFF_W'(previous_sample);
  assign frac_s      = {1'b0, position_acc[FRAC_BITS-1:0]};
  assign count_inc   = output_count + 1'b1;

  assign more = (item_cnt != CAP_W'(PER_ITEM_CAP)) && (output_count < out_length) &&
                (position_acc[POS_W-1:FRAC_BITS] == seg);

  // prev * 2^F + diff * frac, rounded half away from zero, saturated
  always_comb begin
    vsum  = (SUM_W'(previous_sample) <<< FRAC_BITS) + SUM_W'(prod);
    mag   = vsum[SUM_W-1] ? SUM_W'(-vsum) : SUM_W'(vsum);
    rnd   = mag + (SUM_W'(1) << (FRAC_BITS - 1));
    r_mag = rnd[SUM_W-1:FRAC_BITS];
    if (vsum[SUM_W-1]) begin
      if (r_mag >= RMAG_W'(32768)) begin
        lin_val = SAT_MIN;
      end else begin
        lin_val = -$signed(r_mag[SAMPLE_W-1:0]);
      end
    end else begin
      if (r_mag > RMAG_W'(32767)) begin
        lin_val = SAT_MAX;
      end else begin
        lin_val = $signed(r_mag[SAMPLE_W-1:0]);
      end
    end
  end

  assign near_val = ((op_r == OP_DATA) && near_hi) ? next_sample : previous_sample;
  assign out_val  = (interp_mode == MODE_LINEAR) ? lin_val : near_val;

  assign sts.have_prev = have_previous;
  assign sts.more      = more;
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_q16     <= STEP_RESET;
      out_length   <= '0;
      loop_enabled <= 1'b0;
      loop_origin  <= '0;
      interp_mode  <= MODE_LINEAR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_Q16:     step_q16     <= cfg_data[STEP_W-1:0];
        REG_OUT_LENGTH:   out_length   <= cfg_data[LEN_W-1:0];
        REG_LOOP_ENABLED: loop_enabled <= cfg_data[0];
        REG_LOOP_ORIGIN:  loop_origin  <= cfg_data[LEN_W-1:0];
        REG_INTERP_MODE:  interp_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_acc    <= '0;
      previous_sample <= '0;
      loop_sample     <= '0;
      input_index     <= '0;
      output_count    <= '0;
      have_previous   <= 1'b0;
      item_cnt        <= '0;
    end else begin
      if (cmd.start) begin
        item_cnt <= '0;
      end else if (cmd.step) begin
        position_acc <= position_acc + step_frac;
        output_count <= count_inc;
        item_cnt     <= item_cnt + 1'b1;
      end else if (cmd.finish) begin
        if (op_r == OP_END) begin
          position_acc    <= '0;
          previous_sample <= '0;
          loop_sample     <= '0;
          input_index     <= '0;
          output_count    <= '0;
          have_previous   <= 1'b0;
        end else begin
          if (input_index == INDEX_BITS'(loop_origin)) begin
            loop_sample <= sample_r;
          end
          previous_sample <= sample_r;
          have_previous   <= 1'b1;
          input_index     <= input_index + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r     <= in_op;
      sample_r <= in_sample;
      seg      <= input_index - 1'b1;
    end
    if (cmd.step) begin
      prod     <= diff * frac_s;
      near_hi  <= position_acc[FRAC_BITS-1];
      last_cnt <= (count_inc == out_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // last of a flush is known once the next position falls outside the interval
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= out_val;
      out_last <= last_cnt || ((op_r == OP_END) && !more);
    end
  end

endmodule

[rtl/core/linear_nearest_resampler.sv]
// Upsampler for a signed 16-bit sample stream. Each sample beat closes the interval from the
// previous sample and produces the outputs whose positions fall in it (nearest or linear,
// rounded and saturated), at most 16 per beat; an end beat (tuser = 1) flushes the last
// interval and clears the stream. One beat is handled at a time, in the steps accept, first
// check, one step per output and commit; the output steps stall while the output side is
// not ready, since the single output register holds one value. The first sample of a stream
// only opens an interval and, like an end beat with no samples before it, takes only the
// steps accept and commit. Configure only while idle.
module linear_nearest_resampler #(
  parameter int FRAC_BITS  = lnr_pkg::FRAC_BITS_DEF,
  parameter int INDEX_BITS = lnr_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lnr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lnr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] sample_in
  input  logic                          s_axis_tuser,   // [0] operation
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // [15:0] sample_out
  output logic                          m_axis_tlast
);
  import lnr_pkg::*;

  lnr_cmd_t cmd;
  lnr_sts_t sts;
  logic signed [SAMPLE_W-1:0] sample_out;

  lnr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lnr_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (s_axis_tuser),
    .in_sample ($signed(s_axis_tdata)),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (sample_out),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = sample_out;

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("output register overwritten while full");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("new beat accepted while an item is in progress");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (!s_axis_tready && !cmd.finish))
    else $error("output step outside an item");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> m_axis_tvalid)
    else $error("loaded value not presented");

endmodule
